// ===== sv/weth_pkg.sv =====
package weth_pkg;

  // Number of event types, one counter cell each
  localparam int unsigned NUM_TYPES = 64;
  // Width of the dump position counter
  localparam int unsigned CNT_W     = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int unsigned TYPE_W    = 6;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned MASK_W    = 64;
  localparam int unsigned TPW_W     = 16;
  localparam int unsigned CODE_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEGIN_TYPE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_TYPE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_TICK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MSEC_TICK   = 3'd5;

  // Operation codes
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Begin/end code meaning "no type"
  localparam logic [CODE_W-1:0] CODE_NONE = 7'd64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              inc;    // increment the cell that owns inc_type
    logic [TYPE_W-1:0] inc_type;
    logic              shift;  // rotate the chain one cell toward the head
  } cell_ctl_t;

endpackage

// ===== sv/windowed_event_type_histogram_top.sv =====
// Windowed event-type histogram.
// Input beats (s_axis_*): tuser[0] is the operation (0 event, 1 flush),
// tdata[5:0] the event type. Result beats (m_axis_*): tdata[5:0] type index,
// tdata[37:6] saturating count, tlast marks the final enabled type of a dump.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must do so only while idle, which the block does not enforce. Counters
// live in a row of NUM_TYPES cells. Events can stream at one beat per cycle
// while no dump is running. A dump (window end or flush) rotates the chain
// once around with the input held off, one cell position per cycle, each
// enabled position loading the result register. While a result beat waits
// on the receiver the rotation pauses at whatever position it has reached,
// which stretches the dump and keeps the input held off. A dumped counter
// re-enters the chain as zero. Reset (rst_ni low) clears all counters and
// the window count, opens the gate and loads the register defaults; no sweep
// follows.
module windowed_event_type_histogram_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [5:0] event_type
  input  logic [0:0]                      s_axis_tuser,   // [0] operation
  input  logic                            cfg_we_i,
  input  logic [weth_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [weth_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata,   // [5:0] type_index, [37:6] type_count
  output logic                            m_axis_tlast    // last_of_dump
);

  weth_pkg::cell_ctl_t          cell_ctl;
  logic [weth_pkg::COUNT_W-1:0] counts [weth_pkg::NUM_TYPES];
  logic [weth_pkg::COUNT_W-1:0] tail_count;

  weth_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .head_count_i  (counts[0]),
    .tail_count_o  (tail_count),
    .cell_ctl_o    (cell_ctl),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Counter chain; cell i takes cell i+1 on a shift, the last cell the tail
  for (genvar i = 0; i < weth_pkg::NUM_TYPES; i++) begin : g_cell
    logic [weth_pkg::COUNT_W-1:0] shift_in;
    if (i == weth_pkg::NUM_TYPES - 1) begin : g_tail
      assign shift_in = tail_count;
    end else begin : g_mid
      assign shift_in = counts[i+1];
    end
    weth_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (weth_pkg::TYPE_W'(i)),
      .ctl_i      (cell_ctl),
      .shift_in_i (shift_in),
      .count_o    (counts[i])
    );
  end

endmodule

// ===== sv/weth_cell.sv =====
module weth_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [weth_pkg::TYPE_W-1:0]    idx_i,
  input  weth_pkg::cell_ctl_t            ctl_i,
  input  logic [weth_pkg::COUNT_W-1:0]   shift_in_i,
  output logic [weth_pkg::COUNT_W-1:0]   count_o
);

  logic [weth_pkg::COUNT_W-1:0] count_d, count_q;

  // Rotate during a dump, otherwise saturating increment on a match
  always_comb begin
    count_d = count_q;
    if (ctl_i.shift) begin
      count_d = shift_in_i;
    end else if (ctl_i.inc && (ctl_i.inc_type == idx_i) &&
                 (count_q != weth_pkg::COUNT_MAX)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ===== sv/weth_ctrl.sv =====
module weth_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [5:0] event_type
  input  logic [0:0]                        s_axis_tuser,   // [0] operation
  // configuration
  input  logic                              cfg_we_i,
  input  logic [weth_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [weth_pkg::CFG_W-1:0]        cfg_data_i,
  // chain
  input  logic [weth_pkg::COUNT_W-1:0]      head_count_i,
  output logic [weth_pkg::COUNT_W-1:0]      tail_count_o,
  output weth_pkg::cell_ctl_t               cell_ctl_o,
  // result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [39:0]                       m_axis_tdata,   // [5:0] type_index, [37:6] type_count
  output logic                              m_axis_tlast    // last_of_dump
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;
  localparam logic [weth_pkg::CNT_W-1:0] LAST_POS = weth_pkg::CNT_W'(weth_pkg::NUM_TYPES - 1);

  logic state_d, state_q;
  logic [weth_pkg::CNT_W-1:0] pos_d, pos_q;
  logic [weth_pkg::NUM_TYPES-1:0] mrem_d, mrem_q;

  logic [weth_pkg::MASK_W-1:0] type_mask_q;
  logic [weth_pkg::TPW_W-1:0]  tpw_q;
  logic [weth_pkg::CODE_W-1:0] begin_q, end_q;
  logic [weth_pkg::TYPE_W-1:0] sec_q, msec_q;
  logic                        gate_d, gate_q;
  logic [weth_pkg::TPW_W-1:0]  wt_d, wt_q;

  logic                         ov_d, ov_q;
  logic [weth_pkg::TYPE_W-1:0]  oidx_q;
  logic [weth_pkg::COUNT_W-1:0] ocnt_q;
  logic                         olast_q;

  logic                        in_acc, step, start_dump;
  logic                        op;
  logic [weth_pkg::TYPE_W-1:0] ty;
  logic                        in_range, pass_gate, is_end, is_tick;
  logic [weth_pkg::TPW_W-1:0]  wt_inc, limit;

  assign op     = s_axis_tuser[0];
  assign ty     = s_axis_tdata[weth_pkg::TYPE_W-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  // one chain position per cycle unless the result register is blocked
  assign step   = (state_q == ST_DUMP) && (!ov_q || m_axis_tready);

  // Event classification
  assign in_range  = {1'b0, ty} < weth_pkg::CODE_W'(weth_pkg::NUM_TYPES);
  assign pass_gate = gate_q || (!begin_q[weth_pkg::CODE_W-1] &&
                                (ty == begin_q[weth_pkg::TYPE_W-1:0]));
  assign is_end    = !end_q[weth_pkg::CODE_W-1] && (ty == end_q[weth_pkg::TYPE_W-1:0]);
  assign is_tick   = (ty == sec_q) || (ty == msec_q);
  assign wt_inc    = wt_q + 1'b1;
  assign limit     = (tpw_q == '0) ? weth_pkg::TPW_W'(1) : tpw_q;

  // Gate, window, dump start and cell control
  always_comb begin
    gate_d     = gate_q;
    wt_d       = wt_q;
    start_dump = 1'b0;
    cell_ctl_o.inc      = 1'b0;
    cell_ctl_o.inc_type = ty;
    cell_ctl_o.shift    = step;
    if (in_acc) begin
      if (op == weth_pkg::OP_FLUSH) begin
        start_dump = 1'b1;
      end else if (in_range && pass_gate) begin
        gate_d = 1'b1;
        if (is_end) begin
          gate_d = 1'b0;
        end else if (is_tick) begin
          if (wt_inc >= limit) begin
            wt_d       = '0;
            start_dump = 1'b1;
          end else begin
            wt_d = wt_inc;
          end
        end else begin
          cell_ctl_o.inc = type_mask_q[ty];
        end
      end
    end
    if (cfg_we_i && (cfg_idx_i == weth_pkg::REG_BEGIN_TYPE)) begin
      gate_d = cfg_data_i[weth_pkg::CODE_W-1];
    end
  end

  // Dump sequencer: rotates the chain once around
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    mrem_d  = mrem_q;
    if (state_q == ST_IDLE) begin
      if (start_dump) begin
        state_d = ST_DUMP;
        pos_d   = '0;
        mrem_d  = type_mask_q[weth_pkg::NUM_TYPES-1:0];
      end
    end else if (step) begin
      mrem_d = mrem_q >> 1;
      if (pos_q == LAST_POS) begin
        state_d = ST_IDLE;
        pos_d   = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // dumped counters come back cleared, others keep their count
  assign tail_count_o = mrem_q[0] ? '0 : head_count_i;

  always_comb begin
    ov_d = ov_q;
    if (step) begin
      ov_d = mrem_q[0];
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      mrem_q      <= '0;
      gate_q      <= 1'b1;
      wt_q        <= '0;
      ov_q        <= 1'b0;
      type_mask_q <= '1;
      tpw_q       <= weth_pkg::TPW_W'(1);
      begin_q     <= weth_pkg::CODE_NONE;
      end_q       <= weth_pkg::CODE_NONE;
      sec_q       <= weth_pkg::TYPE_W'(0);
      msec_q      <= weth_pkg::TYPE_W'(1);
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      mrem_q  <= mrem_d;
      gate_q  <= gate_d;
      wt_q    <= wt_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          weth_pkg::REG_TYPE_MASK:   type_mask_q <= cfg_data_i[weth_pkg::MASK_W-1:0];
          weth_pkg::REG_TICKS:       tpw_q       <= cfg_data_i[weth_pkg::TPW_W-1:0];
          weth_pkg::REG_BEGIN_TYPE:  begin_q     <= cfg_data_i[weth_pkg::CODE_W-1:0];
          weth_pkg::REG_END_TYPE:    end_q       <= cfg_data_i[weth_pkg::CODE_W-1:0];
          weth_pkg::REG_SECOND_TICK: sec_q       <= cfg_data_i[weth_pkg::TYPE_W-1:0];
          weth_pkg::REG_MSEC_TICK:   msec_q      <= cfg_data_i[weth_pkg::TYPE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload, loaded on an enabled position
  always_ff @(posedge clk_i) begin
    if (step && mrem_q[0]) begin
      oidx_q  <= weth_pkg::TYPE_W'(pos_q);
      ocnt_q  <= head_count_i;
      olast_q <= (mrem_q[weth_pkg::NUM_TYPES-1:1] == '0);
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'b00, ocnt_q, oidx_q};
  assign m_axis_tlast  = olast_q;

  // Chain must not move while the result register is blocked
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP && ov_q && !m_axis_tready) |=> $stable(pos_q))
    else $error("dump position moved during stall");

  // A flush always starts a dump at position zero
  a_flush_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && op == weth_pkg::OP_FLUSH) |=> (state_q == ST_DUMP && pos_q == '0))
    else $error("flush did not start a dump");

  // Between dumps the chain is aligned
  a_idle_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pos_q == '0))
    else $error("chain misaligned while idle");

endmodule

// ===== tb/sv/windowed_event_type_histogram_top_test.sv =====
module windowed_event_type_histogram_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import weth_pkg::*;

  // Cycles with no beat on either side before the run is declared hung
  localparam int unsigned IDLE_LIMIT = 4000;
  // Length of the one long receiver hold-off
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 55;

  typedef enum logic [1:0] {RX_OPEN, RX_SPOTTY, RX_BURSTY} rx_pace_e;

  typedef struct packed {
    logic              op;
    logic [TYPE_W-1:0] ty;
  } hist_evt_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  idx;
    logic [COUNT_W-1:0] count;
    logic               last;
  } hist_bin_t;

  // DUT connections
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // [5:0] event_type
  logic [0:0]           s_axis_tuser  = '0;  // [0] operation
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;        // [5:0] type_index, [37:6] type_count
  logic                 m_axis_tlast;        // last_of_dump

  windowed_event_type_histogram_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Histogram predictor: registers and state
  logic [MASK_W-1:0]  cfg_mask;
  logic [TPW_W-1:0]   cfg_tpw;
  logic [CODE_W-1:0]  cfg_begin;
  logic [CODE_W-1:0]  cfg_end;
  logic [TYPE_W-1:0]  cfg_sec;
  logic [TYPE_W-1:0]  cfg_msec;
  logic [COUNT_W-1:0] hist_cnt [NUM_TYPES];
  logic [TPW_W-1:0]   win_ticks;
  logic               gate_q;

  hist_bin_t   bins_due [$];
  hist_evt_t   events_to_send [$];
  int unsigned issued_cnt   = 0;
  int unsigned taken_cnt    = 0;
  int unsigned mismatch_cnt = 0;

  // Sender and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned mode_left  = 0;
  rx_pace_e    rx_pace    = RX_OPEN;
  bit          long_hold_req = 1'b0;

  task automatic hist_reset();
    cfg_mask  = '1;
    cfg_tpw   = TPW_W'(1);
    cfg_begin = CODE_NONE;
    cfg_end   = CODE_NONE;
    cfg_sec   = TYPE_W'(0);
    cfg_msec  = TYPE_W'(1);
    for (int t = 0; t < NUM_TYPES; t++) hist_cnt[t] = '0;
    win_ticks = '0;
    gate_q    = 1'b1;
  endtask

  // Emit every enabled counter in ascending order, clearing as it goes
  task automatic dump_counts();
    int        last_t;
    hist_bin_t b;
    last_t = -1;
    for (int t = 0; t < NUM_TYPES; t++) if (cfg_mask[t]) last_t = t;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (cfg_mask[t]) begin
        b.idx   = TYPE_W'(t);
        b.count = hist_cnt[t];
        b.last  = (t == last_t);
        bins_due.push_back(b);
        hist_cnt[t] = '0;
      end
    end
  endtask

  task automatic histogram_step(input logic op, input logic [TYPE_W-1:0] ty);
    int unsigned lim;
    if (op == OP_FLUSH) begin
      dump_counts();
      return;
    end
    if (int'(ty) >= NUM_TYPES) return;
    if (!gate_q) begin
      if (cfg_begin < CODE_NONE && {1'b0, ty} == cfg_begin) gate_q = 1'b1;
      else return;
    end
    // end type closes the gate and is dropped
    if (cfg_end < CODE_NONE && {1'b0, ty} == cfg_end) begin
      gate_q = 1'b0;
      return;
    end
    if (ty == cfg_sec || ty == cfg_msec) begin
      lim = (cfg_tpw == '0) ? 1 : cfg_tpw;
      win_ticks = win_ticks + 1'b1;
      if (win_ticks >= lim) begin
        win_ticks = '0;
        dump_counts();
      end
      return;
    end
    if (cfg_mask[ty] && hist_cnt[ty] != COUNT_MAX) hist_cnt[ty] = hist_cnt[ty] + 1'b1;
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_TYPE_MASK:   cfg_mask = val[MASK_W-1:0];
      REG_TICKS:       cfg_tpw  = val[TPW_W-1:0];
      REG_BEGIN_TYPE: begin
        cfg_begin = val[CODE_W-1:0];
        gate_q    = (cfg_begin >= CODE_NONE);
      end
      REG_END_TYPE:    cfg_end  = val[CODE_W-1:0];
      REG_SECOND_TICK: cfg_sec  = val[TYPE_W-1:0];
      REG_MSEC_TICK:   cfg_msec = val[TYPE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random bits above the register width, value below
  function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int unsigned w);
    logic [CFG_W-1:0] j;
    j = {$urandom, $urandom};
    if ($urandom_range(0, 1)) j = '0;
    return (j & ~((64'd1 << w) - 1)) | v;
  endfunction

  task automatic send(input logic op, input logic [TYPE_W-1:0] ty);
    hist_evt_t e;
    e.op = op;
    e.ty = ty;
    events_to_send.push_back(e);
  endtask

  // Wait for every beat sent and every bin out, then for a dump rotation
  task automatic wait_idle();
    while (events_to_send.size() != 0 || issued_cnt != taken_cnt) @(negedge clk_i);
    while (bins_due.size() != 0) @(negedge clk_i);
    repeat (NUM_TYPES + 8) @(negedge clk_i);
  endtask

  // Random traffic shaped by the current registers
  task automatic add_random_events(input int unsigned n);
    logic [TYPE_W-1:0] hot [4];
    logic [TYPE_W-1:0] ty;
    logic              op;
    int unsigned       r;
    for (int k = 0; k < 4; k++) hot[k] = TYPE_W'($urandom_range(0, 63));
    if (cfg_begin < CODE_NONE) send(OP_EVENT, cfg_begin[TYPE_W-1:0]);
    for (int unsigned i = 0; i < n; i++) begin
      r  = $urandom_range(0, 99);
      op = OP_EVENT;
      ty = TYPE_W'($urandom_range(0, 63));
      if (r < 4) op = OP_FLUSH;
      else if (r < 14) ty = cfg_sec;
      else if (r < 22) ty = cfg_msec;
      else if (r < 28 && cfg_begin < CODE_NONE) ty = cfg_begin[TYPE_W-1:0];
      else if (r < 33 && cfg_end < CODE_NONE) ty = cfg_end[TYPE_W-1:0];
      else if (r < 65) ty = hot[$urandom_range(0, 3)];
      send(op, ty);
    end
  endtask

  task automatic report_bad(input string why, input hist_bin_t want, input hist_bin_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_SHOWN)
      $display("%0t mismatch (%s): exp idx=%0d count=%0d last=%0b, got idx=%0d count=%0d last=%0b",
               $realtime, why, want.idx, want.count, want.last, got.idx, got.count, got.last);
  endtask

  // Driver: one beat held until taken, bursts with random gaps
  always @(negedge clk_i) begin : driver
    hist_evt_t nxt;
    if (rst_ni && issued_cnt == taken_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (events_to_send.size() > 0) begin
        nxt = events_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.op;
        s_axis_tdata  <= {{(8-TYPE_W){1'b0}}, nxt.ty};
        issued_cnt++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: changing stall pattern plus one long hold-off on request
  always @(negedge clk_i) begin : receiver
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (mode_left == 0) begin
      rx_pace   = rx_pace_e'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_pace)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_SPOTTY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
          m_axis_tready <= 1'b1;
        end
      endcase
    end
  end

  // Monitor: predict on accepted input beats, check accepted result beats
  always @(posedge clk_i) begin : monitor
    hist_bin_t got;
    hist_bin_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        histogram_step(s_axis_tuser[0], s_axis_tdata[TYPE_W-1:0]);
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx   = m_axis_tdata[TYPE_W-1:0];
        got.count = m_axis_tdata[TYPE_W +: COUNT_W];
        got.last  = m_axis_tlast;
        if (bins_due.size() == 0) begin
          report_bad("beat with nothing due", '0, got);
        end else begin
          want = bins_due.pop_front();
          if (got.idx !== want.idx || got.count !== want.count || got.last !== want.last)
            report_bad("field", want, got);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("windowed_event_type_histogram_top_test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [MASK_W-1:0] m;
    hist_reset();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Defaults: full mask, one tick per window, gate open
    send(OP_EVENT, 6'd63);
    send(OP_EVENT, 6'd2);
    send(OP_EVENT, 6'd2);
    send(OP_FLUSH, 6'd63);
    send(OP_EVENT, 6'd0);
    send(OP_EVENT, 6'd1);
    wait_idle();

    // Gated window, both ticks on one type
    write_reg(REG_TYPE_MASK, 64'h8000_0000_0000_0401);
    write_reg(REG_TICKS, 64'd3);
    write_reg(REG_BEGIN_TYPE, 64'd10);
    write_reg(REG_END_TYPE, 64'd20);
    write_reg(REG_SECOND_TICK, 64'd5);
    write_reg(REG_MSEC_TICK, 64'd5);
    send(OP_EVENT, 6'd7);
    send(OP_EVENT, 6'd10);
    send(OP_EVENT, 6'd63);
    send(OP_EVENT, 6'd0);
    send(OP_EVENT, 6'd5);
    send(OP_EVENT, 6'd5);
    send(OP_EVENT, 6'd20);
    send(OP_EVENT, 6'd63);
    send(OP_EVENT, 6'd10);
    send(OP_EVENT, 6'd5);
    wait_idle();

    // Begin equal to end: opens, closes, dropped
    write_reg(REG_BEGIN_TYPE, 64'd30);
    write_reg(REG_END_TYPE, 64'd30);
    send(OP_EVENT, 6'd30);
    send(OP_EVENT, 6'd31);
    send(OP_FLUSH, 6'd0);
    wait_idle();

    // Empty mask, zero window length, gate reloaded open
    write_reg(REG_TYPE_MASK, 64'd0);
    write_reg(REG_TICKS, 64'd0);
    write_reg(REG_BEGIN_TYPE, CFG_W'(CODE_NONE));
    write_reg(REG_END_TYPE, 64'd0);
    write_reg(REG_SECOND_TICK, 64'd63);
    write_reg(REG_MSEC_TICK, 64'd62);
    send(OP_EVENT, 6'd63);
    send(OP_FLUSH, 6'd17);
    send(OP_EVENT, 6'd0);
    wait_idle();

    // Window length lowered below the running tick count
    write_reg(REG_TYPE_MASK, '1);
    write_reg(REG_BEGIN_TYPE, 64'h7F);
    write_reg(REG_END_TYPE, 64'h7F);
    write_reg(REG_TICKS, 64'd5);
    send(OP_EVENT, 6'd63);
    send(OP_EVENT, 6'd63);
    send(OP_EVENT, 6'd63);
    send(OP_EVENT, 6'd9);
    wait_idle();
    write_reg(REG_TICKS, 64'd2);
    send(OP_EVENT, 6'd62);
    wait_idle();

    // Random phases, each with its own register setting
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       m = '1;
        1:       m = {$urandom, $urandom};
        2:       m = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
        default: m = {$urandom, $urandom} | {$urandom, $urandom};
      endcase
      if (ph == 2) begin
        // full dumps every tick while the receiver holds off
        write_reg(REG_TYPE_MASK, '1);
        write_reg(REG_TICKS, 64'd1);
        write_reg(REG_BEGIN_TYPE, CFG_W'(CODE_NONE));
        write_reg(REG_END_TYPE, CFG_W'(CODE_NONE));
      end else begin
        write_reg(REG_TYPE_MASK, m);
        write_reg(REG_TICKS, with_junk((ph == 5) ? 64'd65535 : $urandom_range(0, 5), TPW_W));
        write_reg(REG_BEGIN_TYPE, with_junk($urandom_range(0, 1) ? CFG_W'(CODE_NONE)
                                            : $urandom_range(0, 63), CODE_W));
        write_reg(REG_END_TYPE, with_junk($urandom_range(0, 1) ? CFG_W'(CODE_NONE)
                                          : $urandom_range(0, 63), CODE_W));
      end
      write_reg(REG_SECOND_TICK, with_junk($urandom_range(0, 63), TYPE_W));
      write_reg(REG_MSEC_TICK, with_junk(($urandom_range(0, 3) == 0) ? cfg_sec
                                         : $urandom_range(0, 63), TYPE_W));
      if (ph == 2) long_hold_req = 1'b1;
      add_random_events(PHASE_LEN);
      wait_idle();
    end

    repeat (NUM_TYPES + 16) @(negedge clk_i);
    if (mismatch_cnt == 0 && bins_due.size() == 0) begin
      $display("windowed_event_type_histogram_top_test passed");
    end else begin
      $display("windowed_event_type_histogram_top_test failed");
    end
    $finish;
  end

endmodule
